/* rtl/pal_pkg.sv */
// package for the positional array list
// holds the list depth, field widths, request and status codes and the
// controller to datapath command type; no dependencies
`default_nettype none

package pal_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = CNT_W;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned REQ_W  = 2;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_READ   = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_APPEND = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } pal_cmd_t;

endpackage

`default_nettype wire

/* rtl/pal_ctrl.sv */
// controller for the positional array list
// sequences capture and execution of a request; uses pal_pkg
`default_nettype none

module pal_ctrl
  import pal_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  output pal_cmd_t      cmd_o,
  output logic          done_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;
  logic done_q, done_d;
  logic accept;

  assign accept = start && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy       = (state_q == S_EXEC);
  assign cmd_o.load = accept;
  assign cmd_o.exec = (state_q == S_EXEC);
  assign done_o     = done_q;

  a_exec_then_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> done_q)
    else $error("execution not followed by result strobe");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy)
    else $error("result strobe while busy");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy && !done_q)
    else $error("accepted transaction did not enter execution");

endmodule

`default_nettype wire

/* rtl/pal_dp.sv */
// datapath for the positional array list
// request register, row of list cells, entry count and result registers; uses pal_pkg
`default_nettype none

module pal_dp
  import pal_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire pal_cmd_t                 cmd_i,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] item_value_i,
  output logic signed [DATA_W-1:0]      read_value_o,
  output logic [STAT_W-1:0]             status_o,
  output logic [CNT_W-1:0]              count_o
);

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  req_e                     req_q;
  logic [POS_W-1:0]         pos_q;
  logic [DATA_W-1:0]        item_q;
  logic [DATA_W-1:0]        cells_q [DEPTH];
  logic [CNT_W-1:0]         count_q, count_d;
  logic [DATA_W-1:0]        value_q, value_d;
  status_e                  status_q, status_d;
  logic                     ok_ins, ok_app, ok_del;
  logic [CNT_W-1:0]         pos_c;
  logic [DATA_W-1:0]        rd_data;

  // position cast to the count width for the range checks
  assign pos_c   = CNT_W'(pos_q);
  assign rd_data = cells_q[pos_q[IDX_W-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_e'(req_type_i);
      pos_q  <= position_i;
      item_q <= item_value_i;
    end
  end

  always_comb begin
    count_d  = count_q;
    value_d  = '0;
    status_d = ST_OK;
    ok_ins   = 1'b0;
    ok_app   = 1'b0;
    ok_del   = 1'b0;
    unique case (req_q)
      REQ_READ: begin
        if (pos_c >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          value_d = rd_data;
        end
      end
      REQ_INSERT: begin
        if (pos_c > count_q) begin
          status_d = ST_RANGE;
        end else if (count_q >= DEPTH_C) begin
          status_d = ST_FULL;
        end else begin
          ok_ins  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      REQ_APPEND: begin
        if (count_q >= DEPTH_C) begin
          status_d = ST_FULL;
        end else begin
          ok_app  = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      REQ_DELETE: begin
        if (pos_c >= count_q) begin
          status_d = ST_RANGE;
        end else begin
          ok_del  = 1'b1;
          value_d = rd_data;
          count_d = count_q - 1'b1;
        end
      end
      default: begin
        status_d = ST_RANGE;
      end
    endcase
  end

  // each cell looks only at its neighbours and the item register; cells past the count may take stale data
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (ok_ins) begin
          if (CNT_W'(i) == pos_c) begin
            cells_q[i] <= item_q;
          end else if ((CNT_W'(i) > pos_c) && (i > 0)) begin
            cells_q[i] <= cells_q[(i > 0) ? i - 1 : 0];
          end
        end else if (ok_app) begin
          if (CNT_W'(i) == count_q) begin
            cells_q[i] <= item_q;
          end
        end else if (ok_del) begin
          if ((CNT_W'(i) >= pos_c) && (i + 1 < DEPTH)) begin
            cells_q[i] <= cells_q[(i + 1 < DEPTH) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  assign read_value_o = value_q;
  assign status_o     = status_q;
  assign count_o      = count_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DEPTH_C)
    else $error("entry count beyond capacity");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && status_d != ST_OK |=> $stable(count_q))
    else $error("failed request changed the entry count");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.load && cmd_i.exec))
    else $error("capture and execution in the same cycle");

endmodule

`default_nettype wire

/* rtl/positional_array_list.sv */
// positional array list: the controller runs a capture then execute sequence; a request
// is captured at the accepting edge; result, status and done_o are registered from the
// execute state. start is taken only when idle (busy is high in the execute state).
// all cells shift in parallel, so insert and delete take the same time at any position.
// reset clears the entry count and the controller; list cells are not reset.
// the receiver cannot stall: each result shows for one cycle with done_o high.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] item_value_i,
  output logic                          done_o,
  output logic signed [DATA_W-1:0]      read_value_o,
  output logic [STAT_W-1:0]             status_o,
  output logic [CNT_W-1:0]              count_o
);

  pal_cmd_t cmd;

  pal_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  pal_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .req_type_i   (req_type_i),
    .position_i   (position_i),
    .item_value_i (item_value_i),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .count_o      (count_o)
  );

endmodule

`default_nettype wire
